// ===== hw/rtl/text_console_cell_writer_macros.svh =====
// Assertion macros for the text console cell writer checker.
// Used by the checker file only; expects clk and rst_n in scope.
`ifndef TEXT_CONSOLE_CELL_WRITER_MACROS_SVH
`define TEXT_CONSOLE_CELL_WRITER_MACROS_SVH

// checked only while out of reset
`define TCCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define TCCW_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/tccw_pkg.sv =====
// Shared types and codes for the text console cell writer.
// No dependencies.
package tccw_pkg;

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_RETURN  = 8'd13;
  localparam logic [7:0] CH_BLANK   = 8'd0;

  // command codes from the front to the back
  localparam logic [2:0] OP_PRINT   = 3'd0;
  localparam logic [2:0] OP_NEWLINE = 3'd1;
  localparam logic [2:0] OP_TAB     = 3'd2;
  localparam logic [2:0] OP_RETURN  = 3'd3;
  localparam logic [2:0] OP_CLEAR   = 3'd4;

  localparam int Q_DEPTH = 2;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] ch;
  } cmd_t;

endpackage

// ===== hw/rtl/tccw_front.sv =====
// Front end: accepts requests, decodes them into commands, holds a 2-entry queue.
// Depends on tccw_pkg.
module tccw_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [7:0]     in_char,
  input  logic           in_kind,
  output logic           cmd_valid,
  input  logic           cmd_ready,
  output tccw_pkg::cmd_t cmd
);

  localparam int PW = $clog2(tccw_pkg::Q_DEPTH);

  tccw_pkg::cmd_t q_r [tccw_pkg::Q_DEPTH];
  logic [PW-1:0]  wp_r, wp_nxt;
  logic [PW-1:0]  rp_r, rp_nxt;
  logic [PW:0]    cnt_r, cnt_nxt;
  tccw_pkg::cmd_t dec;
  logic           push, pop;

  always_comb begin
    dec.ch = in_char;
    if (in_kind) begin
      dec.op = tccw_pkg::OP_CLEAR;
    end else begin
      unique case (in_char)
        tccw_pkg::CH_NEWLINE: dec.op = tccw_pkg::OP_NEWLINE;
        tccw_pkg::CH_TAB:     dec.op = tccw_pkg::OP_TAB;
        tccw_pkg::CH_RETURN:  dec.op = tccw_pkg::OP_RETURN;
        default:              dec.op = tccw_pkg::OP_PRINT;
      endcase
    end
  end

  assign in_tready = en && (cnt_r != (PW+1)'(tccw_pkg::Q_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign cmd_valid = (cnt_r != '0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= dec;
    end
  end

endmodule

// ===== hw/rtl/tccw_back.sv =====
// Back end: cursor tracking, cell store, write sequencer and output register.
// Depends on tccw_pkg.
module tccw_back #(
  parameter int COLUMNS  = 8,
  parameter int CELLS    = 32,
  parameter int TAB_STOP = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  output logic                      init_done,
  input  logic                      cmd_valid,
  output logic                      cmd_ready,
  input  tccw_pkg::cmd_t            cmd,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [$clog2(CELLS)-1:0]  out_index,
  output logic [7:0]                out_char,
  output logic                      out_last
);

  localparam int IW = $clog2(CELLS);
  localparam int CW = $clog2(CELLS + TAB_STOP + COLUMNS) + 1;
  localparam int NW = $clog2(COLUMNS);
  localparam int TW = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;

  localparam logic [CW-1:0] CELLS_C   = CW'(CELLS);
  localparam logic [CW-1:0] COLS_C    = CW'(COLUMNS);
  localparam logic [CW-1:0] SAT_C     = CW'(CELLS + COLUMNS);
  localparam logic [CW-1:0] HOME_C    = CW'(CELLS - COLUMNS);
  localparam logic [IW-1:0] IDX_LAST  = IW'(CELLS - 1);
  localparam logic [NW-1:0] COL_LAST  = NW'(COLUMNS - 1);
  localparam logic [TW-1:0] TAB_LAST  = TW'(TAB_STOP - 1);
  localparam logic [TW-1:0] TSTEP     = TW'(COLUMNS % TAB_STOP);
  localparam logic [TW-1:0] TSAT      = TW'((CELLS - COLUMNS) % TAB_STOP);
  localparam logic [TW:0]   TSTOP_W   = (TW+1)'(TAB_STOP);
  localparam logic [TW:0]   TBACK_W   = (TW+1)'(TAB_STOP - COLUMNS % TAB_STOP);

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_BLANK  = 3'd2;
  localparam logic [2:0] ST_CLEAR  = 3'd3;
  localparam logic [2:0] ST_SCR_RD = 3'd4;
  localparam logic [2:0] ST_SCR_WR = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cur_r, cur_nxt;
  logic [NW-1:0] col_r, col_nxt;
  logic [TW-1:0] tcol_r, tcol_nxt;
  logic [TW-1:0] lt_r, lt_nxt;     // line start modulo tab stop
  logic [IW-1:0] idx_r, idx_nxt;
  logic          tab_r, tab_nxt;

  logic          ovalid_r;
  logic [IW-1:0] oindex_r;
  logic [7:0]    ochar_r;
  logic          olast_r;

  logic [7:0]    mem [CELLS];
  logic [7:0]    rdata_r;

  logic          slot_free;
  logic          emit;
  logic [IW-1:0] e_idx;
  logic [7:0]    e_char;
  logic          e_last;
  logic          we;
  logic [IW-1:0] waddr;
  logic [7:0]    wdata;
  logic          re;
  logic [IW-1:0] raddr;

  // single cell step of the cursor
  logic          col_wrap, tcol_wrap, cur_end, in_range, done;
  logic [NW-1:0] col_inc;
  logic [TW-1:0] tcol_inc, lt_inc, tcol_dec, lt_dec;
  logic [TW:0]   lt_sum;
  logic [CW-1:0] cur_inc, src_addr, nxt_src;
  logic          src_ok, nxt_ok;
  logic [7:0]    scr_val;

  always_comb begin
    col_wrap  = (col_r == COL_LAST);
    col_inc   = col_wrap ? '0 : col_r + 1'b1;
    tcol_wrap = (tcol_r == TAB_LAST);
    tcol_inc  = tcol_wrap ? '0 : tcol_r + 1'b1;
    lt_sum    = (TW+1)'(lt_r) + (TW+1)'(TSTEP);
    lt_inc    = col_wrap ? ((lt_sum >= TSTOP_W) ? TW'(lt_sum - TSTOP_W) : TW'(lt_sum)) : lt_r;
    tcol_dec  = (tcol_r >= TSTEP) ? tcol_r - TSTEP : TW'((TW+1)'(tcol_r) + TBACK_W);
    lt_dec    = (lt_r >= TSTEP) ? lt_r - TSTEP : TW'((TW+1)'(lt_r) + TBACK_W);
    cur_inc   = cur_r + 1'b1;
    cur_end   = (cur_inc >= CELLS_C);
    in_range  = (cur_r < CELLS_C);
    done      = tab_r ? tcol_wrap : col_wrap;
    src_addr  = CW'(idx_r) + COLS_C;
    nxt_src   = src_addr + 1'b1;
    src_ok    = (src_addr < CELLS_C);
    nxt_ok    = (nxt_src < CELLS_C);
    scr_val   = src_ok ? rdata_r : tccw_pkg::CH_BLANK;
  end

  assign slot_free = !ovalid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    col_nxt   = col_r;
    tcol_nxt  = tcol_r;
    lt_nxt    = lt_r;
    idx_nxt   = idx_r;
    tab_nxt   = tab_r;
    cmd_ready = 1'b0;
    emit      = 1'b0;
    e_idx     = cur_r[IW-1:0];
    e_char    = tccw_pkg::CH_BLANK;
    e_last    = 1'b0;
    we        = 1'b0;
    waddr     = cur_r[IW-1:0];
    wdata     = tccw_pkg::CH_BLANK;
    re        = 1'b0;
    raddr     = src_addr[IW-1:0];

    unique case (state_r)
      ST_INIT: begin
        we      = 1'b1;
        waddr   = idx_r;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == IDX_LAST) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.op) inside
            tccw_pkg::OP_CLEAR: begin
              cmd_ready = 1'b1;
              cur_nxt   = '0;
              col_nxt   = '0;
              tcol_nxt  = '0;
              lt_nxt    = '0;
              idx_nxt   = '0;
              state_nxt = ST_CLEAR;
            end
            tccw_pkg::OP_RETURN: begin
              cmd_ready = 1'b1;
              cur_nxt   = cur_r - CW'(col_r);
              col_nxt   = '0;
              tcol_nxt  = lt_r;
            end
            tccw_pkg::OP_NEWLINE, tccw_pkg::OP_TAB: begin
              cmd_ready = 1'b1;
              tab_nxt   = (cmd.op == tccw_pkg::OP_TAB);
              state_nxt = ST_BLANK;
            end
            default: begin
              if (slot_free) begin
                cmd_ready = 1'b1;
                emit      = 1'b1;
                e_char    = cmd.ch;
                e_last    = !cur_end;
                we        = 1'b1;
                wdata     = cmd.ch;
                cur_nxt   = cur_inc;
                col_nxt   = col_inc;
                tcol_nxt  = tcol_inc;
                lt_nxt    = lt_inc;
                if (cur_end) begin
                  state_nxt = ST_SCR_RD;
                end
              end
            end
          endcase
        end
      end

      ST_BLANK: begin
        // cells past the end are stepped over without a write
        if (!in_range || slot_free) begin
          emit     = in_range;
          we       = in_range;
          e_last   = done && !cur_end;
          cur_nxt  = cur_inc;
          col_nxt  = col_inc;
          tcol_nxt = tcol_inc;
          lt_nxt   = lt_inc;
          if (done) begin
            state_nxt = cur_end ? ST_SCR_RD : ST_IDLE;
          end
        end
      end

      ST_CLEAR: begin
        if (slot_free) begin
          emit    = 1'b1;
          e_idx   = idx_r;
          e_last  = (idx_r == IDX_LAST);
          we      = 1'b1;
          waddr   = idx_r;
          idx_nxt = idx_r + 1'b1;
          if (idx_r == IDX_LAST) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_SCR_RD: begin
        if (cur_r >= SAT_C) begin
          cur_nxt  = HOME_C;
          col_nxt  = '0;
          tcol_nxt = TSAT;
          lt_nxt   = TSAT;
        end else begin
          cur_nxt  = cur_r - COLS_C;
          tcol_nxt = tcol_dec;
          lt_nxt   = lt_dec;
        end
        idx_nxt   = '0;
        re        = 1'b1;
        raddr     = COLS_C[IW-1:0];
        state_nxt = ST_SCR_WR;
      end

      ST_SCR_WR: begin
        // read of the source cell runs one step ahead of the write
        if (slot_free) begin
          emit    = 1'b1;
          e_idx   = idx_r;
          e_char  = scr_val;
          e_last  = (idx_r == IDX_LAST);
          we      = 1'b1;
          waddr   = idx_r;
          wdata   = scr_val;
          re      = nxt_ok;
          raddr   = nxt_src[IW-1:0];
          idx_nxt = idx_r + 1'b1;
          if (idx_r == IDX_LAST) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_INIT;
      cur_r    <= '0;
      col_r    <= '0;
      tcol_r   <= '0;
      lt_r     <= '0;
      idx_r    <= '0;
      tab_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cur_r    <= cur_nxt;
      col_r    <= col_nxt;
      tcol_r   <= tcol_nxt;
      lt_r     <= lt_nxt;
      idx_r    <= idx_nxt;
      tab_r    <= tab_nxt;
      if (emit) begin
        ovalid_r <= 1'b1;
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      oindex_r <= e_idx;
      ochar_r  <= e_char;
      olast_r  <= e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign init_done = (state_r != ST_INIT);
  assign out_valid = ovalid_r;
  assign out_index = oindex_r;
  assign out_char  = ochar_r;
  assign out_last  = olast_r;

endmodule

// ===== hw/rtl/text_console_cell_writer.sv =====
// Text console cell writer. Each request is a character (in_tuser = 0) or a clear
// (in_tuser = 1) and produces the cell writes that keep a display in step with the
// internal store of CELLS cells, read as lines of COLUMNS cells. A printable byte
// makes one write; newline and tab make one write per blanked cell (up to COLUMNS
// or TAB_STOP); carriage return makes no write; clear writes all CELLS cells. A
// scroll rewrites all CELLS cells. Each command is registered in the queue between
// the front and back ends before the back end starts on it. The cell store has a
// single write port and takes one cell per cycle while the output is not stalled.
// After reset the store is cleared, during which in_tready stays low. COLUMNS must
// be below CELLS.
// Depends on tccw_pkg, tccw_front and tccw_back.
module text_console_cell_writer #(
  parameter int COLUMNS  = 8,
  parameter int CELLS    = 32,
  parameter int TAB_STOP = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [7:0] in_tdata,   // char_code
  input  logic in_tuser,         // kind
  output logic out_tvalid,
  input  logic out_tready,
  // cell_index, cell_char, zero fill
  output logic [(($clog2(CELLS) + 8 + 7) / 8) * 8 - 1:0] out_tdata,
  output logic out_tlast
);

  localparam int IW          = $clog2(CELLS);
  localparam int OUT_TDATA_W = ((IW + 8 + 7) / 8) * 8;

  logic           init_done;
  logic           cmd_valid;
  logic           cmd_ready;
  tccw_pkg::cmd_t cmd;
  logic [IW-1:0]  out_index;
  logic [7:0]     out_char;

  tccw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (init_done),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_char   (in_tdata),
    .in_kind   (in_tuser),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  tccw_back #(
    .COLUMNS  (COLUMNS),
    .CELLS    (CELLS),
    .TAB_STOP (TAB_STOP)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .init_done (init_done),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_index (out_index),
    .out_char  (out_char),
    .out_last  (out_tlast)
  );

  assign out_tdata = OUT_TDATA_W'({out_char, out_index});

endmodule

// ===== hw/rtl/tccw_checker.sv =====
// Port-level checks for the text console cell writer, bound to the top level.
// Depends on text_console_cell_writer_macros.svh.
`include "text_console_cell_writer_macros.svh"

module tccw_checker #(
  parameter int CELLS = 32
) (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic [7:0] in_tdata,
  input logic in_tuser,
  input logic out_tvalid,
  input logic out_tready,
  input logic [(($clog2(CELLS) + 8 + 7) / 8) * 8 - 1:0] out_tdata,
  input logic out_tlast
);

  localparam int IW = $clog2(CELLS);

  logic [IW-1:0] cell_index;
  logic          unused_in;

  assign cell_index = out_tdata[IW-1:0];
  assign unused_in  = in_tvalid ^ (^in_tdata) ^ in_tuser;

  `TCCW_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "output changed while stalled")
  `TCCW_ASSERT_ANY(a_rst_out, !rst_n |=> !out_tvalid, "write shown right after reset")
  `TCCW_ASSERT_ANY(a_rst_busy, !rst_n |=> !in_tready, "request taken during store clear")
  `TCCW_ASSERT(a_index_range, out_tvalid |-> (cell_index <= IW'(CELLS - 1)) || unused_in, "cell index past the store")

endmodule

bind text_console_cell_writer tccw_checker #(.CELLS(CELLS)) u_tccw_checker (.*);

// ===== test/tb_text_console_cell_writer.sv =====
`timescale 1ns / 1ps
// Testbench for text_console_cell_writer: sends print and clear requests, predicts each
// cell write with a behavioral screen model and checks every write in order.
// Depends on tccw_pkg and the text_console_cell_writer RTL.
module tb_text_console_cell_writer;

  localparam int COLUMNS  = 8;
  localparam int CELLS    = 32;
  localparam int TAB_STOP = 4;
  localparam int IDX_W    = $clog2(CELLS);
  localparam int OUT_W    = ((IDX_W + 8 + 7) / 8) * 8;

  localparam logic KIND_PRINT = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  typedef struct {
    logic [IDX_W-1:0] pos;
    logic [7:0]       ch;
    logic             is_last;
  } cell_write_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata = 8'd0;   // char_code
  logic             in_tuser = 1'b0;   // kind
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;         // cell_index, cell_char, zero fill
  logic             out_tlast;

  // screen image and cursor as the display should see them
  logic [7:0]  screen [CELLS];
  int          cursor_pos;
  cell_write_t pending_writes[$];

  int errors = 0;
  bit in_gaps_on = 1'b1;
  bit out_stalls_on = 1'b1;
  int stall_left = 0;

  text_console_cell_writer #(
    .COLUMNS (COLUMNS),
    .CELLS   (CELLS),
    .TAB_STOP(TAB_STOP)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #4 clk = ~clk;

  // mostly back to back, sometimes short, rarely long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void reset_screen();
    for (int i = 0; i < CELLS; i++) screen[i] = tccw_pkg::CH_BLANK;
    cursor_pos = 0;
  endfunction

  function automatic void queue_write(int pos, logic [7:0] ch);
    cell_write_t w;
    w.pos     = pos[IDX_W-1:0];
    w.ch      = ch;
    w.is_last = 1'b0;
    pending_writes.push_back(w);
  endfunction

  function automatic void blank_until(int target);
    for (int i = cursor_pos; i < target && i < CELLS; i++) begin
      screen[i] = tccw_pkg::CH_BLANK;
      queue_write(i, tccw_pkg::CH_BLANK);
    end
    cursor_pos = target;
  endfunction

  function automatic void predict_cell_writes(logic kind, logic [7:0] code);
    int prior_cnt;
    prior_cnt = pending_writes.size();
    if (kind == KIND_CLEAR) begin
      cursor_pos = 0;
      for (int i = 0; i < CELLS; i++) begin
        screen[i] = tccw_pkg::CH_BLANK;
        queue_write(i, tccw_pkg::CH_BLANK);
      end
    end else begin
      case (code)
        tccw_pkg::CH_NEWLINE: blank_until((cursor_pos / COLUMNS + 1) * COLUMNS);
        tccw_pkg::CH_TAB:     blank_until((cursor_pos / TAB_STOP + 1) * TAB_STOP);
        tccw_pkg::CH_RETURN:  cursor_pos = (cursor_pos / COLUMNS) * COLUMNS;
        default: begin
          if (cursor_pos < CELLS) begin
            screen[cursor_pos] = code;
            queue_write(cursor_pos, code);
          end
          cursor_pos++;
        end
      endcase
      // scroll up one line and rewrite the whole screen
      if (cursor_pos >= CELLS) begin
        for (int i = 0; i + COLUMNS < CELLS; i++) screen[i] = screen[i + COLUMNS];
        for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = tccw_pkg::CH_BLANK;
        cursor_pos -= COLUMNS;
        if (cursor_pos >= CELLS) cursor_pos = CELLS - COLUMNS;
        for (int i = 0; i < CELLS; i++) queue_write(i, screen[i]);
      end
    end
    if (pending_writes.size() > prior_cnt)
      pending_writes[pending_writes.size() - 1].is_last = 1'b1;
  endfunction

  task automatic send_request(input logic kind, input logic [7:0] code);
    int gap;
    gap = in_gaps_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom_range(0, 255));
      in_tuser  <= 1'($urandom_range(0, 1));
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= code;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_cell_writes(kind, code);
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
  endtask

  task automatic test_byte_extremes();
    // zero byte is stored as a blank and still advances the cursor
    send_request(KIND_PRINT, 8'h00);
    send_request(KIND_PRINT, 8'hFF);
    send_request(KIND_PRINT, 8'h80);
    send_request(KIND_PRINT, 8'h7F);
    send_request(KIND_PRINT, 8'h01);
  endtask

  task automatic test_control_codes();
    send_request(KIND_PRINT, tccw_pkg::CH_RETURN);   // mid-line, no write
    send_request(KIND_PRINT, tccw_pkg::CH_TAB);      // blanks over old text
    send_request(KIND_PRINT, tccw_pkg::CH_TAB);      // from a tab stop
    send_request(KIND_PRINT, tccw_pkg::CH_NEWLINE);  // from a line start: full line
    send_request(KIND_PRINT, tccw_pkg::CH_RETURN);   // already at line start
    send_request(KIND_PRINT, "x");
    send_request(KIND_PRINT, tccw_pkg::CH_NEWLINE);
    wait_for_drain();
  endtask

  task automatic test_scroll();
    send_request(KIND_PRINT, tccw_pkg::CH_TAB);
    send_request(KIND_PRINT, tccw_pkg::CH_TAB);      // tab off the end of the screen
    send_request(KIND_PRINT, "Z");
    send_request(KIND_PRINT, tccw_pkg::CH_NEWLINE);  // newline on the last line
    send_request(KIND_PRINT, tccw_pkg::CH_TAB);
    send_request(KIND_PRINT, "a");
    send_request(KIND_PRINT, "b");
    send_request(KIND_PRINT, "c");
    send_request(KIND_PRINT, "d");                   // lands in the last cell
  endtask

  task automatic test_clear();
    // code is ignored on clear
    send_request(KIND_CLEAR, 8'hFF);
    send_request(KIND_PRINT, "q");
    send_request(KIND_CLEAR, 8'h00);
  endtask

  task automatic send_random_request();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2)       send_request(KIND_CLEAR, 8'($urandom_range(0, 255)));
    else if (r < 12) send_request(KIND_PRINT, tccw_pkg::CH_NEWLINE);
    else if (r < 20) send_request(KIND_PRINT, tccw_pkg::CH_TAB);
    else if (r < 25) send_request(KIND_PRINT, tccw_pkg::CH_RETURN);
    else if (r < 40) send_request(KIND_PRINT, 8'($urandom_range(0, 255)));
    else             send_request(KIND_PRINT, 8'($urandom_range(32, 126)));
  endtask

  task automatic test_random_steady(input int n);
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    repeat (n) send_random_request();
    wait_for_drain();
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
  endtask

  task automatic test_random_paced(input int n);
    repeat (n) send_random_request();
  endtask

  always @(negedge clk) begin
    if (out_stalls_on && stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
      if (out_stalls_on && $urandom_range(0, 99) < 25) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin : check_writes
    cell_write_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_writes.size() == 0) begin
        $error("unexpected cell write: cell_index %0d cell_char %0d",
               out_tdata[IDX_W-1:0], out_tdata[IDX_W +: 8]);
        errors++;
      end else begin
        want = pending_writes.pop_front();
        if (out_tdata[IDX_W-1:0] !== want.pos) begin
          $error("cell_index: expected %0d, actual %0d", want.pos, out_tdata[IDX_W-1:0]);
          errors++;
        end
        if (out_tdata[IDX_W +: 8] !== want.ch) begin
          $error("cell_char: expected %0d, actual %0d", want.ch, out_tdata[IDX_W +: 8]);
          errors++;
        end
        if (out_tlast !== want.is_last) begin
          $error("last: expected %0d, actual %0d", want.is_last, out_tlast);
          errors++;
        end
        if (out_tdata[OUT_W-1:IDX_W+8] !== '0) begin
          $error("zero fill: expected 0, actual %0h", out_tdata[OUT_W-1:IDX_W+8]);
          errors++;
        end
      end
    end
  end

  initial begin
    reset_screen();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_byte_extremes();
    test_control_codes();
    test_scroll();
    test_clear();
    test_random_steady(80);
    test_random_paced(290);

    wait_for_drain();
    repeat (CELLS + COLUMNS + 8) @(posedge clk);
    if (pending_writes.size() != 0) begin
      $error("%0d cell writes never arrived", pending_writes.size());
      errors++;
    end
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #16_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/tccw_pkg.sv
hw/rtl/tccw_front.sv
hw/rtl/tccw_back.sv
hw/rtl/text_console_cell_writer.sv
hw/rtl/tccw_checker.sv
test/tb_text_console_cell_writer.sv
